// ----- rtl/core/binary_heap_priority_queue_macros.svh -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: assertion macros
// Shorthand for clocked assertions used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// check outside reset
`define BHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define BHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bhpq_pkg.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: package
// Sizes, codes, state encoding and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;
  localparam int KEY_W    = 32;
  localparam int ACT_W    = 3;
  localparam int STATUS_W = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CHILD_W-1:0]      child_t;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_EXTRACT = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_UPDATE  = 3'd3,
    ACT_DELETE  = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_END,
    S_DN_L,
    S_DN_R,
    S_DN_PUT,
    S_PEEK,
    S_EXT0,
    S_DEL0,
    S_RAISE,
    S_TAKE,
    S_EXT1,
    S_FIN
  } state_t;

  function automatic logic ranks_above(key_t a, key_t b, logic min_mode);
    return min_mode ? (a < b) : (a > b);
  endfunction

  function automatic idx_t parent(idx_t i);
    idx_t d;
    d = i - idx_t'(1);
    return d >> 1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bhpq_in_if.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: command channel
// Valid/ready channel carrying one action with its key and position.
// ---------------------------------------------------------------------------
`default_nettype none

interface bhpq_in_if;
  logic                          valid;
  logic                          ready;
  logic [bhpq_pkg::ACT_W-1:0]    action;
  bhpq_pkg::key_t                key_value;
  logic [bhpq_pkg::IDX_W-1:0]    entry_index;

  modport source (output valid, action, key_value, entry_index, input ready);
  modport sink   (input valid, action, key_value, entry_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bhpq_out_if.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: result channel
// Valid/ready channel carrying one result per command.
// ---------------------------------------------------------------------------
`default_nettype none

interface bhpq_out_if;
  logic                          valid;
  logic                          ready;
  bhpq_pkg::key_t                top_value;
  logic [bhpq_pkg::STATUS_W-1:0] status;
  logic [bhpq_pkg::CNT_W-1:0]    count_after;

  modport source (output valid, top_value, status, count_after, input ready);
  modport sink   (input valid, top_value, status, count_after, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/binary_heap_priority_queue.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue
// Min- or max-heap of signed 32-bit keys held in one synchronous RAM.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per action: insert, extract top, peek,
//   update key at a position, delete at a position. res returns exactly one
//   transaction per command with the key, a status and the entry count.
//   cfg_wr_en/cfg_wr_data write min_mode (1 min-heap, 0 max-heap); write it
//   only while no command is in progress.
// Operation:
//   One command at a time. Each heap level costs one RAM read when sifting
//   up or raising, and two RAM reads when sifting down (left and right
//   child).
// Reset:
//   rst clears the entry count and the result valid flag and sets min mode.
//   RAM contents are not cleared; only positions below the count are read.
// Back-pressure:
//   A finished result waits in the output register; the next command is
//   taken meanwhile and its result holds until res.ready frees the register.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  bhpq_in_if.sink    cmd,
  bhpq_out_if.source res
);

  bhpq_pkg::state_t state, state_next;
  bhpq_pkg::idx_t   hole, hole_next;
  bhpq_pkg::key_t   mkey, mkey_next;
  bhpq_pkg::key_t   ldat, ldat_next;
  bhpq_pkg::cnt_t   cnt, cnt_next;
  logic [bhpq_pkg::ACT_W-1:0]    op, op_next;
  bhpq_pkg::key_t   res_top, res_top_next;
  logic [bhpq_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic             min_mode;

  logic             out_valid;
  bhpq_pkg::key_t   out_top;
  logic [bhpq_pkg::STATUS_W-1:0] out_status;
  bhpq_pkg::cnt_t   out_count;
  logic             out_load;

  logic             ram_we;
  bhpq_pkg::idx_t   ram_waddr;
  bhpq_pkg::key_t   ram_wdata;
  bhpq_pkg::idx_t   ram_raddr;
  logic [bhpq_pkg::KEY_W-1:0] ram_rdata_raw;
  bhpq_pkg::key_t   rdata;

  bhpq_pkg::idx_t   par;
  bhpq_pkg::key_t   m_cur;
  bhpq_pkg::child_t l_cur, r_cur, cnt_ext, nl;
  logic             lv_cur, rv_cur, pick_l, pick_r, nlv, do_down;
  bhpq_pkg::key_t   bv, cval;
  bhpq_pkg::idx_t   child;
  bhpq_pkg::cnt_t   cnt_dec;
  bhpq_pkg::key_t   sentinel;
  logic             bad_index;

  bhpq_ram #(
    .WIDTH (bhpq_pkg::KEY_W),
    .DEPTH (bhpq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign rdata    = bhpq_pkg::key_t'(ram_rdata_raw);
  assign par      = bhpq_pkg::parent(hole);
  assign m_cur    = (state == bhpq_pkg::S_EXT1) ? rdata : mkey;
  assign cnt_ext  = bhpq_pkg::child_t'(cnt);
  assign l_cur    = bhpq_pkg::child_t'({hole, 1'b1});
  assign r_cur    = l_cur + bhpq_pkg::child_t'(1);
  assign lv_cur   = l_cur < cnt_ext;
  assign rv_cur   = r_cur < cnt_ext;
  assign pick_l   = lv_cur && bhpq_pkg::ranks_above(ldat, mkey, min_mode);
  assign bv       = pick_l ? ldat : mkey;
  assign pick_r   = rv_cur && bhpq_pkg::ranks_above(rdata, bv, min_mode);
  assign child    = pick_r ? r_cur[bhpq_pkg::IDX_W-1:0] : l_cur[bhpq_pkg::IDX_W-1:0];
  assign cval     = pick_r ? rdata : ldat;
  assign nl       = bhpq_pkg::child_t'({child, 1'b1});
  assign nlv      = nl < cnt_ext;
  assign cnt_dec  = cnt - bhpq_pkg::cnt_t'(1);
  assign sentinel = min_mode ? bhpq_pkg::KEY_MAX : bhpq_pkg::KEY_MIN;
  assign bad_index = bhpq_pkg::cnt_t'(cmd.entry_index) >= cnt;

  assign cmd.ready       = (state == bhpq_pkg::S_IDLE);
  assign res.valid       = out_valid;
  assign res.top_value   = out_top;
  assign res.status      = out_status;
  assign res.count_after = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bhpq_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      min_mode  <= 1'b1;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) begin
        min_mode <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hole       <= hole_next;
    mkey       <= mkey_next;
    ldat       <= ldat_next;
    op         <= op_next;
    res_top    <= res_top_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_top    <= res_top;
      out_status <= res_status;
      out_count  <= cnt;
    end
  end

  always_comb begin
    state_next      = state;
    hole_next       = hole;
    mkey_next       = mkey;
    ldat_next       = ldat;
    cnt_next        = cnt;
    op_next         = op;
    res_top_next    = res_top;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = hole;
    ram_wdata       = mkey;
    ram_raddr       = '0;
    out_load        = 1'b0;
    do_down         = 1'b0;

    case (state)
      bhpq_pkg::S_IDLE: begin
        if (cmd.valid) begin
          op_next         = cmd.action;
          res_top_next    = '0;
          res_status_next = bhpq_pkg::ST_OK;
          state_next      = bhpq_pkg::S_FIN;
          case (cmd.action)
            bhpq_pkg::ACT_INSERT: begin
              if (cnt == bhpq_pkg::cnt_t'(bhpq_pkg::CAPACITY)) begin
                res_status_next = bhpq_pkg::ST_FULL;
              end else begin
                mkey_next = cmd.key_value;
                hole_next = cnt[bhpq_pkg::IDX_W-1:0];
                cnt_next  = cnt + bhpq_pkg::cnt_t'(1);
                if (cnt == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = cmd.key_value;
                end else begin
                  ram_raddr  = bhpq_pkg::parent(cnt[bhpq_pkg::IDX_W-1:0]);
                  state_next = bhpq_pkg::S_UP;
                end
              end
            end
            bhpq_pkg::ACT_EXTRACT, bhpq_pkg::ACT_PEEK: begin
              if (cnt == '0) begin
                res_top_next    = sentinel;
                res_status_next = bhpq_pkg::ST_EMPTY;
              end else begin
                state_next = (cmd.action == bhpq_pkg::ACT_PEEK) ?
                             bhpq_pkg::S_PEEK : bhpq_pkg::S_EXT0;
              end
            end
            bhpq_pkg::ACT_UPDATE: begin
              if (bad_index) begin
                res_status_next = bhpq_pkg::ST_BAD_INDEX;
              end else begin
                mkey_next = cmd.key_value;
                hole_next = cmd.entry_index;
                if (cmd.entry_index == '0) begin
                  state_next = bhpq_pkg::S_UP_END;
                end else begin
                  ram_raddr  = bhpq_pkg::parent(cmd.entry_index);
                  state_next = bhpq_pkg::S_UP;
                end
              end
            end
            bhpq_pkg::ACT_DELETE: begin
              if (bad_index) begin
                res_status_next = bhpq_pkg::ST_BAD_INDEX;
              end else begin
                hole_next  = cmd.entry_index;
                ram_raddr  = cmd.entry_index;
                state_next = bhpq_pkg::S_DEL0;
              end
            end
            default: begin
              state_next = bhpq_pkg::S_FIN;
            end
          endcase
        end
      end

      bhpq_pkg::S_UP: begin
        if (bhpq_pkg::ranks_above(mkey, rdata, min_mode)) begin
          ram_we    = 1'b1;
          ram_wdata = rdata;
          hole_next = par;
          if (par == '0) begin
            state_next = bhpq_pkg::S_UP_END;
          end else begin
            ram_raddr = bhpq_pkg::parent(par);
          end
        end else if (op == bhpq_pkg::ACT_UPDATE) begin
          do_down = 1'b1;
        end else begin
          ram_we     = 1'b1;
          state_next = bhpq_pkg::S_FIN;
        end
      end

      bhpq_pkg::S_UP_END: begin
        if (op == bhpq_pkg::ACT_UPDATE) begin
          do_down = 1'b1;
        end else begin
          ram_we     = 1'b1;
          state_next = bhpq_pkg::S_FIN;
        end
      end

      bhpq_pkg::S_DN_L: begin
        ldat_next = rdata;
        if (rv_cur) begin
          ram_raddr = r_cur[bhpq_pkg::IDX_W-1:0];
        end
        state_next = bhpq_pkg::S_DN_R;
      end

      bhpq_pkg::S_DN_R: begin
        ram_we = 1'b1;
        if (pick_l || pick_r) begin
          ram_wdata = cval;
          hole_next = child;
          if (nlv) begin
            ram_raddr  = nl[bhpq_pkg::IDX_W-1:0];
            state_next = bhpq_pkg::S_DN_L;
          end else begin
            state_next = bhpq_pkg::S_DN_PUT;
          end
        end else begin
          state_next = bhpq_pkg::S_FIN;
        end
      end

      bhpq_pkg::S_DN_PUT: begin
        ram_we     = 1'b1;
        state_next = bhpq_pkg::S_FIN;
      end

      bhpq_pkg::S_PEEK: begin
        res_top_next = rdata;
        state_next   = bhpq_pkg::S_FIN;
      end

      bhpq_pkg::S_EXT0: begin
        res_top_next = rdata;
        state_next   = bhpq_pkg::S_TAKE;
      end

      bhpq_pkg::S_DEL0: begin
        res_top_next = rdata;
        if (hole == '0) begin
          state_next = bhpq_pkg::S_TAKE;
        end else begin
          ram_raddr  = par;
          state_next = bhpq_pkg::S_RAISE;
        end
      end

      bhpq_pkg::S_RAISE: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
        hole_next = par;
        if (par == '0) begin
          state_next = bhpq_pkg::S_TAKE;
        end else begin
          ram_raddr = bhpq_pkg::parent(par);
        end
      end

      bhpq_pkg::S_TAKE: begin
        cnt_next  = cnt_dec;
        hole_next = '0;
        if (cnt_dec == '0) begin
          state_next = bhpq_pkg::S_FIN;
        end else begin
          ram_raddr  = cnt_dec[bhpq_pkg::IDX_W-1:0];
          state_next = bhpq_pkg::S_EXT1;
        end
      end

      bhpq_pkg::S_EXT1: begin
        do_down = 1'b1;
      end

      bhpq_pkg::S_FIN: begin
        if (!out_valid || res.ready) begin
          out_load   = 1'b1;
          state_next = bhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bhpq_pkg::S_IDLE;
      end
    endcase

    if (do_down) begin
      mkey_next = m_cur;
      if (lv_cur) begin
        ram_raddr  = l_cur[bhpq_pkg::IDX_W-1:0];
        state_next = bhpq_pkg::S_DN_L;
      end else begin
        ram_we     = 1'b1;
        ram_waddr  = hole;
        ram_wdata  = m_cur;
        state_next = bhpq_pkg::S_FIN;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bhpq_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/bhpq_checker.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: port checker
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_heap_priority_queue_macros.svh"

module bhpq_port_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [bhpq_pkg::STATUS_W-1:0] res_status,
  input wire logic [bhpq_pkg::CNT_W-1:0]    res_count
);

  logic over_cap, at_cap, none_held, is_full, is_empty;

  assign over_cap  = res_count > bhpq_pkg::cnt_t'(bhpq_pkg::CAPACITY);
  assign at_cap    = res_count == bhpq_pkg::cnt_t'(bhpq_pkg::CAPACITY);
  assign none_held = res_count == '0;
  assign is_full   = res_status == bhpq_pkg::ST_FULL;
  assign is_empty  = res_status == bhpq_pkg::ST_EMPTY;

  `BHPQ_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `BHPQ_ASSERT_ALWAYS(a_rst_clear, rst |=> !res_valid, "result valid after reset")
  `BHPQ_ASSERT(a_count_cap, res_valid |-> !over_cap, "count beyond capacity")
  `BHPQ_ASSERT(a_full_count, res_valid && is_full |-> at_cap, "full reported below capacity")
  `BHPQ_ASSERT(a_empty_count, res_valid && is_empty |-> none_held, "empty with entries held")

endmodule

bind binary_heap_priority_queue bhpq_port_checker u_bhpq_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_count  (res.count_after)
);

`default_nettype wire

// ----- tb/bhpq_checker.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: result checker
// Watches the command and result channels, keeps its own heap of keys in the
// selected order and compares every result against the predicted one.
// ---------------------------------------------------------------------------
module bhpq_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  logic [bhpq_pkg::ACT_W-1:0] cmd_action,
  input  bhpq_pkg::key_t cmd_key,
  input  bhpq_pkg::idx_t cmd_index,
  input  logic res_valid,
  input  logic res_ready,
  input  bhpq_pkg::key_t res_top,
  input  logic [bhpq_pkg::STATUS_W-1:0] res_status,
  input  bhpq_pkg::cnt_t res_count,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bhpq_pkg::key_t    top;
    bhpq_pkg::status_t status;
    bhpq_pkg::cnt_t    count;
  } heap_result_t;

  bhpq_pkg::key_t heap_keys [bhpq_pkg::CAPACITY];
  int             heap_size;
  logic           order_min;
  heap_result_t   result_queue [$];

  function automatic bit outranks(bhpq_pkg::key_t a, bhpq_pkg::key_t b);
    return order_min ? (a < b) : (a > b);
  endfunction

  function automatic void swap_keys(int a, int b);
    bhpq_pkg::key_t t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic int raise_key(int i);
    while (i > 0 && outranks(heap_keys[i], heap_keys[(i - 1) / 2])) begin
      swap_keys(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
    return i;
  endfunction

  function automatic void sink_key(int i);
    int l, r, best;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      best = i;
      if (l < heap_size && outranks(heap_keys[l], heap_keys[best])) best = l;
      if (r < heap_size && outranks(heap_keys[r], heap_keys[best])) best = r;
      if (best == i) return;
      swap_keys(i, best);
      i = best;
    end
  endfunction

  function automatic bhpq_pkg::key_t pop_root();
    bhpq_pkg::key_t root;
    root = heap_keys[0];
    heap_size--;
    if (heap_size > 0) begin
      heap_keys[0] = heap_keys[heap_size];
      sink_key(0);
    end
    return root;
  endfunction

  function automatic heap_result_t apply_action(logic [bhpq_pkg::ACT_W-1:0] act,
                                                bhpq_pkg::key_t key, int idx);
    heap_result_t r;
    bhpq_pkg::key_t empty_key;
    r.top = '0;
    r.status = bhpq_pkg::ST_OK;
    empty_key = order_min ? bhpq_pkg::KEY_MAX : bhpq_pkg::KEY_MIN;
    case (act)
      bhpq_pkg::ACT_INSERT: begin
        if (heap_size >= bhpq_pkg::CAPACITY) r.status = bhpq_pkg::ST_FULL;
        else begin
          heap_keys[heap_size] = key;
          heap_size++;
          void'(raise_key(heap_size - 1));
        end
      end
      bhpq_pkg::ACT_EXTRACT, bhpq_pkg::ACT_PEEK: begin
        if (heap_size == 0) begin
          r.top = empty_key;
          r.status = bhpq_pkg::ST_EMPTY;
        end else if (act == bhpq_pkg::ACT_EXTRACT) r.top = pop_root();
        else r.top = heap_keys[0];
      end
      bhpq_pkg::ACT_UPDATE: begin
        if (idx >= heap_size) r.status = bhpq_pkg::ST_BAD_INDEX;
        else begin
          heap_keys[idx] = key;
          sink_key(raise_key(idx));
        end
      end
      bhpq_pkg::ACT_DELETE: begin
        if (idx >= heap_size) r.status = bhpq_pkg::ST_BAD_INDEX;
        else begin
          r.top = heap_keys[idx];
          while (idx > 0) begin
            swap_keys(idx, (idx - 1) / 2);
            idx = (idx - 1) / 2;
          end
          void'(pop_root());
        end
      end
      default: ;
    endcase
    r.count = bhpq_pkg::cnt_t'(heap_size);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      heap_size = 0;
      order_min = 1'b1;
      errors = 0;
      result_queue.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) order_min = cfg_wr_data;
      if (res_valid && res_ready) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result transaction: top %0d", res_top);
          errors++;
        end else begin
          want = result_queue.pop_front();
          if (res_top !== want.top) begin
            $error("top_value: expected %0d, got %0d", want.top, res_top);
            errors++;
          end
          if (res_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_status);
            errors++;
          end
          if (res_count !== want.count) begin
            $error("count_after: expected %0d, got %0d", want.count, res_count);
            errors++;
          end
        end
      end
      if (cmd_valid && cmd_ready)
        result_queue.push_back(apply_action(cmd_action, cmd_key, int'(cmd_index)));
      pending = result_queue.size();
    end
  end
endmodule

// ----- tb/tb_binary_heap_priority_queue.sv -----
// ---------------------------------------------------------------------------
// Binary heap priority queue: testbench
// Drives directed and random heap actions in both orders with random idling
// on both channels; a checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_binary_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  int   errors, pending;
  int   send_idle, recv_idle;
  int   model_size;

  bhpq_in_if  cmd ();
  bhpq_out_if res ();

  binary_heap_priority_queue u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd.sink), .res(res.source)
  );

  bhpq_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd_action(cmd.action),
    .cmd_key(cmd.key_value), .cmd_index(cmd.entry_index),
    .res_valid(res.valid), .res_ready(res.ready), .res_top(res.top_value),
    .res_status(res.status), .res_count(res.count_after),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.action = '0;
    cmd.key_value = '0;
    cmd.entry_index = '0;
    res.ready = 1'b0;
  end

  always @(negedge clk) res.ready <= ($urandom_range(99) >= recv_idle);

  task automatic send(logic [bhpq_pkg::ACT_W-1:0] act, bhpq_pkg::key_t key,
                      bhpq_pkg::idx_t idx);
    while ($urandom_range(99) < send_idle) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.action <= act;
    cmd.key_value <= key;
    cmd.entry_index <= idx;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
    // rough size track to steer stimulus
    case (act)
      bhpq_pkg::ACT_INSERT: if (model_size < bhpq_pkg::CAPACITY) model_size++;
      bhpq_pkg::ACT_EXTRACT: if (model_size > 0) model_size--;
      bhpq_pkg::ACT_DELETE: if (int'(idx) < model_size) model_size--;
      default: ;
    endcase
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_order(logic min_order);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= min_order;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic bhpq_pkg::key_t any_key();
    case ($urandom_range(7))
      0: return bhpq_pkg::KEY_MAX;
      1: return bhpq_pkg::KEY_MIN;
      2: return bhpq_pkg::key_t'($urandom_range(20)) - 10;
      default: return bhpq_pkg::key_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    bhpq_pkg::idx_t idx;
    repeat (n) begin
      r = $urandom_range(99);
      idx = (model_size > 0 && $urandom_range(9) != 0) ?
            bhpq_pkg::idx_t'($urandom_range(model_size - 1)) : bhpq_pkg::idx_t'($urandom);
      if (r < 40) send(bhpq_pkg::ACT_INSERT, any_key(), bhpq_pkg::idx_t'($urandom));
      else if (r < 58) send(bhpq_pkg::ACT_EXTRACT, any_key(), bhpq_pkg::idx_t'($urandom));
      else if (r < 68) send(bhpq_pkg::ACT_PEEK, any_key(), bhpq_pkg::idx_t'($urandom));
      else if (r < 82) send(bhpq_pkg::ACT_UPDATE, any_key(), idx);
      else if (r < 96) send(bhpq_pkg::ACT_DELETE, any_key(), idx);
      else send(bhpq_pkg::ACT_W'($urandom_range(7, 5)), any_key(), idx);
    end
  endtask

  initial begin
    model_size = 0;
    send_idle = 9;
    recv_idle = 66;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: empty heap, extremes, every action, bad indexes
    send(bhpq_pkg::ACT_PEEK, '0, '0);
    send(bhpq_pkg::ACT_EXTRACT, '0, '0);
    send(bhpq_pkg::ACT_UPDATE, bhpq_pkg::KEY_MAX, '0);
    send(bhpq_pkg::ACT_DELETE, '0, bhpq_pkg::idx_t'(1023));
    send(bhpq_pkg::ACT_INSERT, bhpq_pkg::KEY_MAX, '0);
    send(bhpq_pkg::ACT_INSERT, bhpq_pkg::KEY_MIN, '0);
    send(bhpq_pkg::ACT_INSERT, '0, '0);
    send(bhpq_pkg::ACT_INSERT, -32'sd1, '0);
    send(bhpq_pkg::ACT_INSERT, 32'sd5, '0);
    send(bhpq_pkg::ACT_PEEK, '0, '0);
    send(bhpq_pkg::ACT_UPDATE, bhpq_pkg::KEY_MIN, bhpq_pkg::idx_t'(3));
    send(bhpq_pkg::ACT_UPDATE, bhpq_pkg::KEY_MAX, bhpq_pkg::idx_t'(0));
    send(bhpq_pkg::ACT_UPDATE, '0, bhpq_pkg::idx_t'(5));
    send(bhpq_pkg::ACT_DELETE, '0, bhpq_pkg::idx_t'(4));
    send(bhpq_pkg::ACT_DELETE, '0, bhpq_pkg::idx_t'(1023));
    send(3'd5, bhpq_pkg::KEY_MAX, bhpq_pkg::idx_t'(1023));
    send(3'd7, bhpq_pkg::KEY_MIN, '0);
    set_order(1'b0);
    send(bhpq_pkg::ACT_PEEK, '0, '0);
    send(bhpq_pkg::ACT_INSERT, 32'sd7, '0);
    send(bhpq_pkg::ACT_EXTRACT, '0, '0);
    send(bhpq_pkg::ACT_DELETE, '0, '0);
    while (model_size > 0) send(bhpq_pkg::ACT_EXTRACT, '0, '0);
    send(bhpq_pkg::ACT_EXTRACT, '0, '0);
    send(bhpq_pkg::ACT_PEEK, '0, '0);
    random_phase(280);
    set_order(1'b1);
    send_idle = 66;
    recv_idle = 9;
    random_phase(280);
    set_order(1'b0);
    send_idle = 0;
    recv_idle = 0;
    random_phase(150);
    // change order with entries held
    send(bhpq_pkg::ACT_INSERT, bhpq_pkg::KEY_MIN, '0);
    send(bhpq_pkg::ACT_UPDATE, bhpq_pkg::KEY_MAX, bhpq_pkg::idx_t'(1023));
    set_order(1'b1);
    random_phase(120);
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
